### src/avccfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avccfg_pkg
// Shared types, reset values and helpers for the AVC configuration record
// parser.
// ----------------------------------------------------------------------------
package avccfg_pkg;

  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_PROFILE  = 4'd1,
    PH_COMPAT   = 4'd2,
    PH_LEVEL    = 4'd3,
    PH_LENSIZE  = 4'd4,
    PH_SPSCOUNT = 4'd5,
    PH_LENHI    = 4'd6,
    PH_LENLO    = 4'd7,
    PH_PAYLOAD  = 4'd8,
    PH_PPSCOUNT = 4'd9,
    PH_EXT0     = 4'd10,
    PH_EXT1     = 4'd11,
    PH_EXT2     = 4'd12,
    PH_EXTCOUNT = 4'd13,
    PH_TRAIL    = 4'd14
  } phase_t;

  localparam logic [1:0] GRP_SPS = 2'd0;
  localparam logic [1:0] GRP_PPS = 2'd1;
  localparam logic [1:0] GRP_EXT = 2'd2;

  localparam logic [7:0] PROF_HIGH    = 8'd100;
  localparam logic [7:0] PROF_HIGH10  = 8'd110;
  localparam logic [7:0] PROF_HIGH422 = 8'd122;
  localparam logic [7:0] PROF_HIGH444 = 8'd144;

  localparam logic [7:0] SPS_COUNT_MASK = 8'h1F;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  group;
    logic [7:0]  sets_left;
    logic [7:0]  set_counter;
    logic [15:0] payload_left;
    logic [7:0]  length_high;
    logic [31:0] byte_count;
    logic        record_done;
    logic [7:0]  profile_reg;
    logic [7:0]  level_reg;
    logic [2:0]  length_size_reg;
    logic [7:0]  ext_fields;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:           PH_VERSION,
    group:           2'd0,
    sets_left:       8'd0,
    set_counter:     8'd0,
    payload_left:    16'd0,
    length_high:     8'd0,
    byte_count:      32'd0,
    record_done:     1'b0,
    profile_reg:     8'd0,
    level_reg:       8'd0,
    length_size_reg: 3'd1,
    ext_fields:      8'd0
  };

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [1:0]  set_group;
    logic [7:0]  set_index;
    logic        done_res;
    logic        parse_error;
    logic [31:0] consumed_bytes;
    logic [7:0]  profile;
    logic [7:0]  level;
    logic [2:0]  nal_length_size;
    logic [1:0]  chroma_fmt;
    logic [2:0]  luma_depth_minus8;
    logic [2:0]  chroma_depth_minus8;
  } result_t;

  function automatic phase_t advance_sets(input logic [1:0] grp, input logic [7:0] left,
                                          input logic [7:0] prof);
    logic has_ext;
    has_ext = (prof == PROF_HIGH) || (prof == PROF_HIGH10) ||
              (prof == PROF_HIGH422) || (prof == PROF_HIGH444);
    if (left != 8'd0) begin
      return PH_LENHI;
    end else if (grp == GRP_SPS) begin
      return PH_PPSCOUNT;
    end else if (grp == GRP_PPS && has_ext) begin
      return PH_EXT0;
    end
    return PH_TRAIL;
  endfunction

endpackage

### src/avc_config_record_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avc_config_record_parser
// Byte-serial parser for an AVC decoder configuration record.
// ----------------------------------------------------------------------------
// One word is one record byte; every accepted byte yields exactly one result
// word, registered in the next cycle. A byte is accepted every cycle as long as
// the result register is empty or being drained, so throughput is one byte per
// clock, set by the single parse-state register updated per byte. The byte
// marked last carries status and decoded header fields, and the parser then
// starts over at the version byte of a new buffer.
module avc_config_record_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  byte_role,
  output logic [1:0]  set_group,
  output logic [7:0]  set_index,
  output logic        done_res,
  output logic        parse_error,
  output logic [31:0] consumed_bytes,
  output logic [7:0]  profile,
  output logic [7:0]  level,
  output logic [2:0]  nal_length_size,
  output logic [1:0]  chroma_fmt,
  output logic [2:0]  luma_depth_minus8,
  output logic [2:0]  chroma_depth_minus8
);

  avccfg_pkg::state_t  state;
  avccfg_pkg::state_t  state_next;
  avccfg_pkg::result_t res_next;
  avccfg_pkg::result_t res;
  logic                in_acc;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  avccfg_step u_step (
    .cur       (state),
    .data_byte (data_byte),
    .last      (last),
    .nxt       (state_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avccfg_pkg::STATE_RESET;
    end else if (in_acc) begin
      state <= last ? avccfg_pkg::STATE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res <= res_next;
    end
  end

  assign byte_role           = res.byte_role;
  assign set_group           = res.set_group;
  assign set_index           = res.set_index;
  assign done_res            = res.done_res;
  assign parse_error         = res.parse_error;
  assign consumed_bytes      = res.consumed_bytes;
  assign profile             = res.profile;
  assign level               = res.level;
  assign nal_length_size     = res.nal_length_size;
  assign chroma_fmt          = res.chroma_fmt;
  assign luma_depth_minus8   = res.luma_depth_minus8;
  assign chroma_depth_minus8 = res.chroma_depth_minus8;

endmodule

### src/avccfg_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avccfg_step
// Next-state and result logic for one record byte.
// ----------------------------------------------------------------------------
module avccfg_step (
  input  avccfg_pkg::state_t  cur,
  input  logic [7:0]          data_byte,
  input  logic                last,
  output avccfg_pkg::state_t  nxt,
  output avccfg_pkg::result_t res
);

  logic [15:0] len;
  logic [15:0] pay_dec;
  logic        in_set;

  assign len     = {cur.length_high, data_byte};
  assign pay_dec = cur.payload_left - 16'd1;
  assign in_set  = (cur.phase == avccfg_pkg::PH_LENHI) ||
                   (cur.phase == avccfg_pkg::PH_LENLO) ||
                   (cur.phase == avccfg_pkg::PH_PAYLOAD);

  always_comb begin
    nxt = cur;
    if (!cur.record_done) begin
      nxt.byte_count = cur.byte_count + 32'd1;
    end
    case (cur.phase)
      avccfg_pkg::PH_VERSION: nxt.phase = avccfg_pkg::PH_PROFILE;
      avccfg_pkg::PH_PROFILE: begin
        nxt.profile_reg = data_byte;
        nxt.phase       = avccfg_pkg::PH_COMPAT;
      end
      avccfg_pkg::PH_COMPAT: nxt.phase = avccfg_pkg::PH_LEVEL;
      avccfg_pkg::PH_LEVEL: begin
        nxt.level_reg = data_byte;
        nxt.phase     = avccfg_pkg::PH_LENSIZE;
      end
      avccfg_pkg::PH_LENSIZE: begin
        nxt.length_size_reg = {1'b0, data_byte[1:0]} + 3'd1;
        nxt.phase           = avccfg_pkg::PH_SPSCOUNT;
      end
      avccfg_pkg::PH_SPSCOUNT: begin
        nxt.group       = avccfg_pkg::GRP_SPS;
        nxt.sets_left   = data_byte & avccfg_pkg::SPS_COUNT_MASK;
        nxt.set_counter = 8'd0;
        nxt.phase       = avccfg_pkg::advance_sets(nxt.group, nxt.sets_left,
                                                   cur.profile_reg);
      end
      avccfg_pkg::PH_LENHI: begin
        nxt.length_high = data_byte;
        nxt.phase       = avccfg_pkg::PH_LENLO;
      end
      avccfg_pkg::PH_LENLO: begin
        if (len == 16'd0) begin
          nxt.sets_left   = cur.sets_left - 8'd1;
          nxt.set_counter = cur.set_counter + 8'd1;
          nxt.phase       = avccfg_pkg::advance_sets(cur.group, nxt.sets_left,
                                                     cur.profile_reg);
        end else begin
          nxt.payload_left = len;
          nxt.phase        = avccfg_pkg::PH_PAYLOAD;
        end
      end
      avccfg_pkg::PH_PAYLOAD: begin
        nxt.payload_left = pay_dec;
        if (pay_dec == 16'd0) begin
          nxt.sets_left   = cur.sets_left - 8'd1;
          nxt.set_counter = cur.set_counter + 8'd1;
          nxt.phase       = avccfg_pkg::advance_sets(cur.group, nxt.sets_left,
                                                     cur.profile_reg);
        end
      end
      avccfg_pkg::PH_PPSCOUNT: begin
        nxt.group       = avccfg_pkg::GRP_PPS;
        nxt.sets_left   = data_byte;
        nxt.set_counter = 8'd0;
        nxt.phase       = avccfg_pkg::advance_sets(nxt.group, nxt.sets_left,
                                                   cur.profile_reg);
      end
      avccfg_pkg::PH_EXT0: begin
        nxt.ext_fields[7:6] = data_byte[1:0];
        nxt.phase           = avccfg_pkg::PH_EXT1;
      end
      avccfg_pkg::PH_EXT1: begin
        nxt.ext_fields[5:3] = data_byte[2:0];
        nxt.phase           = avccfg_pkg::PH_EXT2;
      end
      avccfg_pkg::PH_EXT2: begin
        nxt.ext_fields[2:0] = data_byte[2:0];
        nxt.phase           = avccfg_pkg::PH_EXTCOUNT;
      end
      avccfg_pkg::PH_EXTCOUNT: begin
        nxt.group       = avccfg_pkg::GRP_EXT;
        nxt.sets_left   = data_byte;
        nxt.set_counter = 8'd0;
        nxt.phase       = avccfg_pkg::advance_sets(nxt.group, nxt.sets_left,
                                                   cur.profile_reg);
      end
      default: nxt.phase = cur.phase;
    endcase
    nxt.record_done = cur.record_done || (nxt.phase == avccfg_pkg::PH_TRAIL);
  end

  always_comb begin
    res             = '0;
    res.byte_role   = cur.phase;
    res.set_group   = in_set ? cur.group : 2'd0;
    res.set_index   = in_set ? cur.set_counter : 8'd0;
    if (last) begin
      res.done_res            = 1'b1;
      res.parse_error         = !nxt.record_done;
      res.consumed_bytes      = nxt.record_done ? nxt.byte_count : 32'd0;
      res.profile             = nxt.profile_reg;
      res.level               = nxt.level_reg;
      res.nal_length_size     = nxt.length_size_reg;
      res.chroma_fmt          = nxt.ext_fields[7:6];
      res.luma_depth_minus8   = nxt.ext_fields[5:3];
      res.chroma_depth_minus8 = nxt.ext_fields[2:0];
    end
  end

endmodule

### src/avccfg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avccfg_checker
// Port-level checks for the AVC configuration record parser.
// ----------------------------------------------------------------------------
module avccfg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  byte_role,
  input logic        done_res,
  input logic        parse_error,
  input logic [31:0] consumed_bytes,
  input logic [2:0]  nal_length_size
);

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_role) && $stable(done_res))
    else $error("stalled result word changed");

  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> !parse_error && consumed_bytes == 32'd0)
    else $error("status fields set on a non-final word");

  a_error_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && parse_error |-> consumed_bytes == 32'd0)
    else $error("byte count reported with an error");

  a_len_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> nal_length_size != 3'd0 && nal_length_size <= 3'd4)
    else $error("NAL length size out of range");

  a_role: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_role != 4'd15)
    else $error("invalid byte role");

endmodule

bind avc_config_record_parser avccfg_checker u_avccfg_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .byte_role       (byte_role),
  .done_res        (done_res),
  .parse_error     (parse_error),
  .consumed_bytes  (consumed_bytes),
  .nal_length_size (nal_length_size)
);
